>>> sv/mandel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot pixel core package
// Q4.28 format constants, register indices, reset values, saturation and
// the 16-entry colour palette.
// ----------------------------------------------------------------------------
package mandel_pkg;

	localparam int FRAC_BITS = 28;

	typedef logic signed [31:0] q428_t;
	typedef logic [2:0]         reg_idx_t;
	typedef logic [23:0]        rgb_t;

	// register indices on the config port
	localparam reg_idx_t REG_MAX_ITER    = 3'd0;
	localparam reg_idx_t REG_REAL_ORIGIN = 3'd1;
	localparam reg_idx_t REG_REAL_STEP   = 3'd2;
	localparam reg_idx_t REG_IMAG_ORIGIN = 3'd3;
	localparam reg_idx_t REG_IMAG_STEP   = 3'd4;

	localparam logic [15:0] RST_MAX_ITER    = 16'd10000;
	localparam q428_t       RST_REAL_ORIGIN = -32'sd671088640;  // -2.5
	localparam q428_t       RST_REAL_STEP   = 32'sd918401;      // 3.5 / 1023
	localparam q428_t       RST_IMAG_ORIGIN = 32'sd268435456;   // 1.0
	localparam q428_t       RST_IMAG_STEP   = -32'sd699962;     // -2.0 / 767

	// |z|^2 escape bound, 4.0 in Q8.56
	localparam logic [63:0] ESCAPE_BOUND = 64'h0400_0000_0000_0000;

	// clamp a wide signed value to the Q4.28 range
	function automatic q428_t sat_q428(input logic signed [47:0] v);
		q428_t r;
		if (v > 48'sh0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic rgb_t palette(input logic [3:0] idx);
		rgb_t c;
		unique case (idx)
			4'd0:  c = {8'd66,  8'd30,  8'd15};
			4'd1:  c = {8'd25,  8'd7,   8'd26};
			4'd2:  c = {8'd9,   8'd1,   8'd47};
			4'd3:  c = {8'd4,   8'd4,   8'd73};
			4'd4:  c = {8'd0,   8'd7,   8'd100};
			4'd5:  c = {8'd12,  8'd44,  8'd138};
			4'd6:  c = {8'd24,  8'd82,  8'd177};
			4'd7:  c = {8'd57,  8'd125, 8'd209};
			4'd8:  c = {8'd134, 8'd181, 8'd229};
			4'd9:  c = {8'd211, 8'd236, 8'd248};
			4'd10: c = {8'd241, 8'd233, 8'd191};
			4'd11: c = {8'd248, 8'd201, 8'd95};
			4'd12: c = {8'd255, 8'd170, 8'd0};
			4'd13: c = {8'd204, 8'd128, 8'd0};
			4'd14: c = {8'd153, 8'd87,  8'd0};
			4'd15: c = {8'd106, 8'd52,  8'd3};
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> sv/mandelbrot_escape_time_pixel_core.sv
`default_nettype none
// The time from input beat to result grows with the number of iterations
// until the point escapes or the limit is reached; output stalls add to it.
// The core works on one pixel at a time; each iteration runs in four steps on the
// single shared 32x32 multiplier (zr*zr, zi*zi, zr*zi, then the update).
// The next input beat is taken once the result sits in the output register.
// Reset (arst_n low, asynchronous) empties the core and loads the default view.
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core
// Maps a pixel to c in Q4.28, iterates z = z*z + c with one multiplier and
// returns the iteration count, in-set flag and palette colour.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [9:0]  pixel_x,
	input  wire logic [9:0]  pixel_y,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [9:0]       out_x,
	output logic [9:0]       out_y,
	output logic [15:0]      iteration_count,
	output logic             inside_set,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CR   = 4'd1;  // px * real_step
	localparam logic [3:0] ST_CI   = 4'd2;  // cr, py * imag_step
	localparam logic [3:0] ST_CIM  = 4'd3;  // ci
	localparam logic [3:0] ST_RR   = 4'd4;  // limit test, zr*zr
	localparam logic [3:0] ST_II   = 4'd5;  // zi*zi
	localparam logic [3:0] ST_RI   = 4'd6;  // escape test, zr*zi
	localparam logic [3:0] ST_UPD  = 4'd7;  // new z
	localparam logic [3:0] ST_FIN  = 4'd8;  // hand result to output register

	logic [3:0]           state_q;
	logic [15:0]          max_iter_q;
	mandel_pkg::q428_t    real_origin_q, real_step_q, imag_origin_q, imag_step_q;
	logic [9:0]           px_q, py_q;
	mandel_pkg::q428_t    cr_q, ci_q, zr_q, zi_q;
	logic [15:0]          count_q;
	logic                 inside_q;
	logic signed [63:0]   prod_q, rr_q, diff_q;

	mandel_pkg::q428_t    mul_a, mul_b;
	logic signed [63:0]   mul_p;
	logic [63:0]          mag;
	logic signed [63:0]   diff_sh, prod_sh;
	logic                 in_beat, out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign out_load = (state_q == ST_FIN) && (!out_valid || !out_stall);

	// shared multiplier operand select
	always_comb begin
		mul_a = zr_q;
		mul_b = zr_q;
		unique case (state_q)
			ST_CR: begin
				mul_a = {22'd0, px_q};
				mul_b = real_step_q;
			end
			ST_CI: begin
				mul_a = {22'd0, py_q};
				mul_b = imag_step_q;
			end
			ST_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			ST_RI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign mag     = rr_q + prod_q;
	assign diff_sh = diff_q >>> mandel_pkg::FRAC_BITS;
	assign prod_sh = prod_q >>> (mandel_pkg::FRAC_BITS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q    <= mandel_pkg::RST_MAX_ITER;
			real_origin_q <= mandel_pkg::RST_REAL_ORIGIN;
			real_step_q   <= mandel_pkg::RST_REAL_STEP;
			imag_origin_q <= mandel_pkg::RST_IMAG_ORIGIN;
			imag_step_q   <= mandel_pkg::RST_IMAG_STEP;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mandel_pkg::REG_MAX_ITER:    max_iter_q    <= cfg_wdata[15:0];
				mandel_pkg::REG_REAL_ORIGIN: real_origin_q <= cfg_wdata;
				mandel_pkg::REG_REAL_STEP:   real_step_q   <= cfg_wdata;
				mandel_pkg::REG_IMAG_ORIGIN: imag_origin_q <= cfg_wdata;
				mandel_pkg::REG_IMAG_STEP:   imag_step_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_beat) state_q <= ST_CR;
				ST_CR:   state_q <= ST_CI;
				ST_CI:   state_q <= ST_CIM;
				ST_CIM:  state_q <= ST_RR;
				ST_RR:   state_q <= (count_q >= max_iter_q) ? ST_FIN : ST_II;
				ST_II:   state_q <= ST_RI;
				ST_RI:   state_q <= (mag > mandel_pkg::ESCAPE_BOUND) ? ST_FIN : ST_UPD;
				ST_UPD:  state_q <= ST_RR;
				ST_FIN:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					px_q    <= pixel_x;
					py_q    <= pixel_y;
					zr_q    <= '0;
					zi_q    <= '0;
					count_q <= '0;
				end
			end
			ST_CI: begin
				cr_q <= mandel_pkg::sat_q428({{16{real_origin_q[31]}}, real_origin_q}
					+ prod_q[47:0]);
			end
			ST_CIM: begin
				ci_q <= mandel_pkg::sat_q428({{16{imag_origin_q[31]}}, imag_origin_q}
					+ prod_q[47:0]);
			end
			ST_RR: begin
				inside_q <= 1'b1;
			end
			ST_II: begin
				rr_q <= prod_q;
			end
			ST_RI: begin
				diff_q   <= rr_q - prod_q;
				inside_q <= 1'b0;
			end
			ST_UPD: begin
				zr_q    <= mandel_pkg::sat_q428(diff_sh[47:0] + {{16{cr_q[31]}}, cr_q});
				zi_q    <= mandel_pkg::sat_q428(prod_sh[47:0] + {{16{ci_q[31]}}, ci_q});
				count_q <= count_q + 16'd1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x           <= px_q;
			out_y           <= py_q;
			iteration_count <= count_q;
			inside_set      <= inside_q;
			{red, green, blue} <= inside_q ? '0 : mandel_pkg::palette(count_q[3:0]);
		end
	end

`ifndef NO_ASSERTIONS
	a_beat_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q == ST_CR)
		else $error("accepted beat did not start setup");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FIN)
		else $error("result appeared without finishing a pixel");

	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && inside_set) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
		else $error("in-set pixel is not black");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> count_q == 16'($past(count_q) + 16'd1))
		else $error("iteration count did not advance by one");
`endif

endmodule
`default_nettype wire
